// ===== design/pgr_pkg.sv =====
// Shared types and constants for the PCM gain and requantizer.
package pgr_pkg;

  // Fixed-point gain format and datapath widths.
  localparam int GAIN_FRAC_BITS = 30;
  localparam int SAMPLE_W       = 32;
  localparam int GAIN_W         = 31;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int VB_W           = 6;
  localparam int PAD_W          = 5;
  localparam int PROD_W         = SAMPLE_W + GAIN_W;
  localparam int SUM_W          = PROD_W + 1;
  localparam int SCALED_W       = SUM_W - GAIN_FRAC_BITS;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(64'd1 << GAIN_FRAC_BITS);
  localparam logic [SUM_W-1:0]  GAIN_HALF  = SUM_W'(64'd1 << (GAIN_FRAC_BITS - 1));

  localparam logic [VB_W-1:0] VB_MIN = VB_W'(8);
  localparam logic [VB_W-1:0] VB_MAX = VB_W'(32);

  // Pipeline depth from an accepted item to its result strobe.
  localparam int PIPE_DEPTH = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN     = 2'd0,
    CFG_FORMAT   = 2'd1,
    CFG_SIG_BITS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_word;
    logic                in_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       out_last;
  } out_t;

  // Sign-magnitude item handed from the gain section to the requantizer.
  typedef struct packed {
    logic                valid;
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic                last;
  } stage_t;

endpackage

// ===== design/pcm_int_gain_requantizer.sv =====
// Top level of the PCM gain and requantizer.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  input     | start, busy               | item   (sample_word, in_last)
//  result    | done (one-cycle strobe)   | result (out_sample, out_last)
//  config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One transaction is taken every cycle outside reset; the result strobe of a
// transaction comes through the five pipeline registers around the 32x31 gain
// multiplier and the two rounding adders, one strobe per item, in order. Reset is
// synchronous: busy stays high and cfg_ready low while rst is high, the pipeline
// empties and the registers return to unity gain, 16-bit source and 32 valid bits.
// The receiver cannot stall, so the pipeline always advances and busy is low
// outside reset.
module pcm_int_gain_requantizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  pgr_pkg::in_t                      item,
  output logic                              done,
  output pgr_pkg::out_t                     result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pgr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [pgr_pkg::GAIN_W-1:0] gain_q30;
  logic                       source_format;
  logic [pgr_pkg::VB_W-1:0]   sig_bits;
  logic                       take;
  pgr_pkg::stage_t            stage;

  // Hold off transactions only during reset.
  assign busy      = rst;
  assign cfg_ready = ~rst;
  assign take      = start & ~busy;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_q30      <= pgr_pkg::GAIN_UNITY;
      source_format <= 1'b0;
      sig_bits      <= pgr_pkg::VB_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pgr_pkg::CFG_GAIN:     gain_q30      <= cfg_data[pgr_pkg::GAIN_W-1:0];
        pgr_pkg::CFG_FORMAT:   source_format <= cfg_data[0];
        pgr_pkg::CFG_SIG_BITS: sig_bits      <= cfg_data[pgr_pkg::VB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stages 1-3: decode, multiply, round and saturate to 32 bits.
  pgr_gain u_gain (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (item),
    .gain  (gain_q30),
    .fmt32 (source_format),
    .stage (stage)
  );

  // Stages 4-5: round to valid bits, clamp, restore sign.
  pgr_requant u_requant (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .sig_bits (sig_bits),
    .done     (done),
    .result   (result)
  );

endmodule

// ===== design/pgr_gain.sv =====
// Gain section: sign-magnitude conversion, gain multiply, rounding and saturation.
module pgr_gain (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  pgr_pkg::in_t                item,
  input  logic [pgr_pkg::GAIN_W-1:0]  gain,
  input  logic                        fmt32,
  output pgr_pkg::stage_t             stage
);

  // Stage 1: sign and magnitude of the source sample
  logic                          valid1;
  logic                          neg1;
  logic [pgr_pkg::SAMPLE_W-1:0]  mag1;
  logic                          last1;
  logic [pgr_pkg::SAMPLE_W-1:0]  s32;

  // Stage 2: full product
  logic                          valid2;
  logic                          neg2;
  logic [pgr_pkg::PROD_W-1:0]    prod2;
  logic                          last2;

  // Stage 3: rounded and saturated magnitude
  logic [pgr_pkg::SUM_W-1:0]     sum3;
  logic [pgr_pkg::SCALED_W-1:0]  scaled3;
  logic [pgr_pkg::SCALED_W-1:0]  lim3;

  assign s32 = fmt32 ? item.sample_word
                     : {item.sample_word[15:0], 16'h0000};

  assign sum3    = {1'b0, prod2} + pgr_pkg::GAIN_HALF;
  assign scaled3 = sum3[pgr_pkg::SUM_W-1:pgr_pkg::GAIN_FRAC_BITS];
  // Negative side reaches one step further than positive.
  assign lim3    = neg2 ? pgr_pkg::SCALED_W'(64'h8000_0000)
                        : pgr_pkg::SCALED_W'(64'h7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1      <= 1'b0;
      valid2      <= 1'b0;
      stage.valid <= 1'b0;
    end else begin
      valid1      <= take;
      valid2      <= valid1;
      stage.valid <= valid2;
    end

    neg1  <= s32[pgr_pkg::SAMPLE_W-1];
    mag1  <= s32[pgr_pkg::SAMPLE_W-1] ? (~s32 + 1'b1) : s32;
    last1 <= item.in_last;

    neg2  <= neg1;
    prod2 <= pgr_pkg::PROD_W'(mag1) * pgr_pkg::PROD_W'(gain);
    last2 <= last1;

    stage.neg  <= neg2;
    stage.mag  <= (scaled3 > lim3) ? lim3[pgr_pkg::SAMPLE_W-1:0]
                                   : scaled3[pgr_pkg::SAMPLE_W-1:0];
    stage.last <= last2;
  end

endmodule

// ===== design/pgr_requant.sv =====
// Requantizer: round to the valid bit count, clamp and restore the sign.
module pgr_requant (
  input  logic                       clk,
  input  logic                       rst,
  input  pgr_pkg::stage_t            stage,
  input  logic [pgr_pkg::VB_W-1:0]   sig_bits,
  output logic                       done,
  output pgr_pkg::out_t              result
);

  logic [pgr_pkg::VB_W-1:0]      vb_eff;
  logic [pgr_pkg::VB_W-1:0]      pad_full;
  logic [pgr_pkg::PAD_W-1:0]     pad;
  logic [pgr_pkg::SAMPLE_W:0]    half;
  logic [pgr_pkg::SAMPLE_W-1:0]  mask;

  // Stage 4: rounding add
  logic                          valid4;
  logic                          neg4;
  logic [pgr_pkg::SAMPLE_W:0]    rnd4;
  logic                          last4;

  // Stage 5 logic
  logic [pgr_pkg::SAMPLE_W:0]    trunc5;
  logic [pgr_pkg::SAMPLE_W-1:0]  neg_val;
  logic [pgr_pkg::SAMPLE_W-1:0]  out_val;

  always_comb begin
    if (sig_bits < pgr_pkg::VB_MIN) begin
      vb_eff = pgr_pkg::VB_MIN;
    end else if (sig_bits > pgr_pkg::VB_MAX) begin
      vb_eff = pgr_pkg::VB_MAX;
    end else begin
      vb_eff = sig_bits;
    end
  end

  assign pad_full = pgr_pkg::VB_MAX - vb_eff;
  assign pad      = pad_full[pgr_pkg::PAD_W-1:0];
  assign half     = (pad == '0) ? '0 : ((pgr_pkg::SAMPLE_W+1)'(1) << (pad - 1'b1));
  assign mask     = (pgr_pkg::SAMPLE_W'(1) << pad) - 1'b1;

  assign trunc5  = rnd4 & ~{1'b0, mask};
  assign neg_val = ~trunc5[pgr_pkg::SAMPLE_W-1:0] + 1'b1;

  always_comb begin
    if (neg4) begin
      out_val = (trunc5 > (pgr_pkg::SAMPLE_W+1)'(64'h8000_0000)) ? 32'h8000_0000 : neg_val;
    end else begin
      out_val = trunc5[pgr_pkg::SAMPLE_W] | trunc5[pgr_pkg::SAMPLE_W-1]
              ? (32'h7FFF_FFFF & ~mask) : trunc5[pgr_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid4 <= stage.valid;
      done   <= valid4;
    end

    neg4  <= stage.neg;
    rnd4  <= {1'b0, stage.mag} + half;
    last4 <= stage.last;

    result.out_sample <= out_val;
    result.out_last   <= last4;
  end

endmodule

// ===== design/pgr_checker.sv =====
// Port-level checks for the PCM gain and requantizer, bound to the top level.
module pgr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input pgr_pkg::in_t                   item,
  input logic                           done,
  input pgr_pkg::out_t                  result
);

  // Every accepted transaction yields its result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(pgr_pkg::PIPE_DEPTH) done)
    else $error("result strobe missing after transaction");

  // No strobe without a matching earlier transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, pgr_pkg::PIPE_DEPTH))
    else $error("result strobe without transaction");

  // The last marker travels with its sample.
  a_last: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(pgr_pkg::PIPE_DEPTH)
      (result.out_last == $past(item.in_last, pgr_pkg::PIPE_DEPTH)))
    else $error("last marker mismatch");

  // Input is refused only in reset.
  a_busy: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");

endmodule

bind pcm_int_gain_requantizer pgr_checker u_pgr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
